// File: design/assert_macros.svh
// Assertion helper macros shared by the matvec core RTL.
// No dependencies; pulled in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with active-low asynchronous reset masking.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true at a clock edge.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `ASSERT_CLK(lbl, clk, rst_n, !(cond), msg)

`endif

// File: design/btm_pkg.sv
// Shared types, sizes and codes for the block-Toeplitz complex matvec core.
// No dependencies; used by btm_seq, btm_cmac and the top level through scoped names.
package btm_pkg;

  localparam int MAX_COLS    = 256;
  localparam int MAX_ROWS    = 16;
  localparam int STORE_DEPTH = MAX_COLS * MAX_ROWS;

  localparam int IDX_W  = 12;  // flat index field width
  localparam int COLS_W = 9;   // cols_in_use register width
  localparam int ROWS_W = 5;   // rows_in_use register width
  localparam int TOT_W  = $clog2(STORE_DEPTH + 1);
  localparam int MX_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int MZ_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int ACC_W  = 80;  // 4096 products of up to 2^63 fit with margin
  localparam int ACC_HI_W = ACC_W - 63;  // accumulator bits that must match the sign
  localparam int DATA_W = 32;
  localparam int ENTRY_W = 2 * DATA_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = COLS_W;

  localparam logic [CFG_IDX_W-1:0] CFG_COLS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    ACT_KERNEL  = 2'd0,
    ACT_VECTOR  = 2'd1,
    ACT_COMPUTE = 2'd2,
    ACT_NONE    = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_SAT   = 2'd2
  } stat_e;

  typedef struct packed {
    act_e               action;
    logic [IDX_W-1:0]   index;
    logic signed [31:0] value_re;
    logic signed [31:0] value_im;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [63:0] result_re;
    logic signed [63:0] result_im;
  } out_word_t;

  // Per-element control riding alongside the store reads.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } elem_t;

  // Finished dot product from the MAC unit.
  typedef struct packed {
    logic               done;
    logic               sat;
    logic signed [63:0] re;
    logic signed [63:0] im;
  } mac_res_t;

endpackage

// File: design/btm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module btm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/btm_seq.sv
// Sequencer: splits the output index into block row/column by repeated
// subtraction, then walks all matrix columns generating store addresses.
// Depends on btm_pkg.
module btm_seq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [btm_pkg::IDX_W-1:0]   k_i,
  input  logic [btm_pkg::COLS_W-1:0]  cols_i,
  input  logic [btm_pkg::ROWS_W-1:0]  rows_i,
  output logic [btm_pkg::ADDR_W-1:0]  kaddr_o,
  output logic [btm_pkg::ADDR_W-1:0]  vaddr_o,
  output btm_pkg::elem_t              ctl_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_SCAN
  } state_e;

  state_e                      state_q;
  logic [btm_pkg::IDX_W-1:0]   rem_q;
  logic [btm_pkg::IDX_W-1:0]   kbase_q;   // |bz-mz| * cols
  logic [btm_pkg::MZ_W-1:0]    bz_q;
  logic [btm_pkg::MX_W-1:0]    bx_q;
  logic [btm_pkg::MX_W-1:0]    dx_q;      // |bx-mx|
  logic [btm_pkg::MZ_W-1:0]    mz_q;
  logic [btm_pkg::MX_W-1:0]    mx_q;
  logic [btm_pkg::IDX_W-1:0]   vi_q;
  logic [btm_pkg::IDX_W-1:0]   cols_ext;
  logic                        last_col;
  logic                        last_row;

  assign cols_ext = btm_pkg::IDX_W'(cols_i);
  assign last_col = btm_pkg::COLS_W'(mx_q) == (cols_i - btm_pkg::COLS_W'(1));
  assign last_row = btm_pkg::ROWS_W'(mz_q) == (rows_i - btm_pkg::ROWS_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rem_q   <= '0;
      kbase_q <= '0;
      bz_q    <= '0;
      bx_q    <= '0;
      dx_q    <= '0;
      mz_q    <= '0;
      mx_q    <= '0;
      vi_q    <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            rem_q   <= k_i;
            kbase_q <= '0;
            bz_q    <= '0;
            mz_q    <= '0;
            mx_q    <= '0;
            vi_q    <= '0;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem_q >= cols_ext) begin
            rem_q   <= rem_q - cols_ext;
            kbase_q <= kbase_q + cols_ext;
            bz_q    <= bz_q + 1'b1;
          end else begin
            bx_q    <= rem_q[btm_pkg::MX_W-1:0];
            dx_q    <= rem_q[btm_pkg::MX_W-1:0];
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          vi_q <= vi_q + 1'b1;
          if (last_col) begin
            mx_q <= '0;
            dx_q <= bx_q;
            mz_q <= mz_q + 1'b1;
            // distance to the block row shrinks until mz passes bz
            if (mz_q < bz_q) begin
              kbase_q <= kbase_q - cols_ext;
            end else begin
              kbase_q <= kbase_q + cols_ext;
            end
            if (last_row) begin
              state_q <= S_IDLE;
            end
          end else begin
            mx_q <= mx_q + 1'b1;
            if (mx_q < bx_q) begin
              dx_q <= dx_q - 1'b1;
            end else begin
              dx_q <= dx_q + 1'b1;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign kaddr_o     = btm_pkg::ADDR_W'(kbase_q + btm_pkg::IDX_W'(dx_q));
  assign vaddr_o     = btm_pkg::ADDR_W'(vi_q);
  assign ctl_o.valid = (state_q == S_SCAN);
  assign ctl_o.first = (vi_q == '0);
  assign ctl_o.last  = last_col && last_row;

endmodule

// File: design/btm_cmac.sv
// Pipelined complex multiply-accumulate with 64-bit saturation of the sums.
// Depends on btm_pkg; inputs arrive in the cycle after the store read issue.
module btm_cmac (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  btm_pkg::elem_t               ctl_i,
  input  logic [btm_pkg::ENTRY_W-1:0]  kern_i,
  input  logic [btm_pkg::ENTRY_W-1:0]  vec_i,
  output btm_pkg::mac_res_t            res_o
);

  btm_pkg::elem_t                    s1_q;
  btm_pkg::elem_t                    s2_q;
  logic                              done_q;
  logic signed [63:0]                p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [btm_pkg::ACC_W-1:0]  acc_re_q, acc_im_q;
  logic signed [btm_pkg::ACC_W-1:0]  term_re, term_im;
  logic signed [31:0]                ar, ai, br, bi;
  logic [btm_pkg::ACC_HI_W-1:0]      hi_re, hi_im;
  logic                              fit_re, fit_im;

  // entry layout: real part high, imaginary part low
  assign ar = kern_i[63:32];
  assign ai = kern_i[31:0];
  assign br = vec_i[63:32];
  assign bi = vec_i[31:0];

  assign term_re = btm_pkg::ACC_W'(p_rr_q) - btm_pkg::ACC_W'(p_ii_q);
  assign term_im = btm_pkg::ACC_W'(p_ri_q) + btm_pkg::ACC_W'(p_ir_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q   <= '0;
      s2_q   <= '0;
      done_q <= 1'b0;
    end else begin
      s1_q   <= ctl_i;
      s2_q   <= s1_q;
      done_q <= s2_q.valid && s2_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_q.valid) begin
      p_rr_q <= 64'(ar) * 64'(br);
      p_ii_q <= 64'(ai) * 64'(bi);
      p_ri_q <= 64'(ar) * 64'(bi);
      p_ir_q <= 64'(ai) * 64'(br);
    end
    if (s2_q.valid) begin
      acc_re_q <= s2_q.first ? term_re : acc_re_q + term_re;
      acc_im_q <= s2_q.first ? term_im : acc_im_q + term_im;
    end
  end

  assign hi_re  = acc_re_q[btm_pkg::ACC_W-1:63];
  assign hi_im  = acc_im_q[btm_pkg::ACC_W-1:63];
  assign fit_re = (hi_re == '0) || (hi_re == '1);
  assign fit_im = (hi_im == '0) || (hi_im == '1);

  assign res_o.done = done_q;
  assign res_o.sat  = !fit_re || !fit_im;
  assign res_o.re   = fit_re ? acc_re_q[63:0] :
                      (acc_re_q[btm_pkg::ACC_W-1] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}});
  assign res_o.im   = fit_im ? acc_im_q[63:0] :
                      (acc_im_q[btm_pkg::ACC_W-1] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}});

endmodule

// File: design/block_toeplitz_complex_matvec_core.sv
// Top level of the symmetric block-Toeplitz complex matvec core.
// Depends on btm_pkg, btm_ram, btm_seq, btm_cmac and assert_macros.svh.
//
//   channel | direction | handshake                 | word
//   --------+-----------+---------------------------+-------------------
//   in      | to core   | in_valid_i / in_stall_o   | btm_pkg::in_word_t
//   out     | from core | out_valid_o / out_stall_i | btm_pkg::out_word_t
//   cfg     | to core   | cfg_we_i (no handshake)   | cfg_idx_i, cfg_data_i
//
// Loads, out-of-range indexes and the unused action go straight to the output register.
// A compute word first splits its index by repeated subtraction, then streams
// one matrix column per cycle through the shared complex MAC (one read port per
// store), then passes a four-stage drain into the output register.
// Reset returns cols_in_use to 256 and rows_in_use to 16; stores are not cleared.
// in_stall_o is high during a compute and while an untaken result blocks out.
`include "assert_macros.svh"

module block_toeplitz_complex_matvec_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  btm_pkg::in_word_t                  in_word_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output btm_pkg::out_word_t                 out_word_o,
  input  logic                               cfg_we_i,
  input  logic [btm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [btm_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  // configuration registers, raw as written
  logic [btm_pkg::COLS_W-1:0]  cols_q;
  logic [btm_pkg::ROWS_W-1:0]  rows_q;
  logic [btm_pkg::COLS_W-1:0]  cols_eff;
  logic [btm_pkg::ROWS_W-1:0]  rows_eff;
  logic [btm_pkg::TOT_W-1:0]   total;

  logic                        busy_q;
  logic                        out_valid_q;
  btm_pkg::out_word_t          out_word_q;

  logic                        in_accept;
  logic                        in_range;
  logic                        kern_we, vec_we, start;
  logic [btm_pkg::ENTRY_W-1:0] wdata;
  logic [btm_pkg::ADDR_W-1:0]  waddr;
  logic [btm_pkg::ADDR_W-1:0]  kaddr, vaddr;
  logic [btm_pkg::ENTRY_W-1:0] kern_rd, vec_rd;
  btm_pkg::elem_t              elem;
  btm_pkg::mac_res_t           mac_res;

  // out-of-range sizes: zero acts as one, too large acts as the maximum
  always_comb begin
    if (cols_q == '0) begin
      cols_eff = btm_pkg::COLS_W'(1);
    end else if (cols_q > btm_pkg::COLS_W'(btm_pkg::MAX_COLS)) begin
      cols_eff = btm_pkg::COLS_W'(btm_pkg::MAX_COLS);
    end else begin
      cols_eff = cols_q;
    end
    if (rows_q == '0) begin
      rows_eff = btm_pkg::ROWS_W'(1);
    end else if (rows_q > btm_pkg::ROWS_W'(btm_pkg::MAX_ROWS)) begin
      rows_eff = btm_pkg::ROWS_W'(btm_pkg::MAX_ROWS);
    end else begin
      rows_eff = rows_q;
    end
  end

  assign total = btm_pkg::TOT_W'(cols_eff) * btm_pkg::TOT_W'(rows_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= btm_pkg::COLS_W'(btm_pkg::MAX_COLS);
      rows_q <= btm_pkg::ROWS_W'(btm_pkg::MAX_ROWS);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == btm_pkg::CFG_COLS) begin
        cols_q <= cfg_data_i;
      end else if (cfg_idx_i == btm_pkg::CFG_ROWS) begin
        rows_q <= cfg_data_i[btm_pkg::ROWS_W-1:0];
      end
    end
  end

  // input side
  assign in_stall_o = busy_q || (out_valid_q && out_stall_i);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_range   = btm_pkg::TOT_W'(in_word_i.index) < total;

  assign kern_we = in_accept && in_range && (in_word_i.action == btm_pkg::ACT_KERNEL);
  assign vec_we  = in_accept && in_range && (in_word_i.action == btm_pkg::ACT_VECTOR);
  assign start   = in_accept && in_range && (in_word_i.action == btm_pkg::ACT_COMPUTE);
  assign wdata   = {in_word_i.value_re, in_word_i.value_im};
  assign waddr   = btm_pkg::ADDR_W'(in_word_i.index);

  btm_ram #(
    .WIDTH (btm_pkg::ENTRY_W),
    .DEPTH (btm_pkg::STORE_DEPTH)
  ) u_kern_ram (
    .clk_i   (clk_i),
    .we_i    (kern_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (kaddr),
    .rdata_o (kern_rd)
  );

  btm_ram #(
    .WIDTH (btm_pkg::ENTRY_W),
    .DEPTH (btm_pkg::STORE_DEPTH)
  ) u_vec_ram (
    .clk_i   (clk_i),
    .we_i    (vec_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (vaddr),
    .rdata_o (vec_rd)
  );

  btm_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .k_i     (in_word_i.index),
    .cols_i  (cols_eff),
    .rows_i  (rows_eff),
    .kaddr_o (kaddr),
    .vaddr_o (vaddr),
    .ctl_o   (elem)
  );

  btm_cmac u_cmac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (elem),
    .kern_i (kern_rd),
    .vec_i  (vec_rd),
    .res_o  (mac_res)
  );

  // busy from compute start until the MAC hands back the sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start) begin
      busy_q <= 1'b1;
    end else if (mac_res.done) begin
      busy_q <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (mac_res.done || (in_accept && !start)) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mac_res.done) begin
      out_word_q.status    <= mac_res.sat ? btm_pkg::ST_SAT : btm_pkg::ST_OK;
      out_word_q.result_re <= mac_res.re;
      out_word_q.result_im <= mac_res.im;
    end else if (in_accept && !start) begin
      // loads, unused action and range errors carry zero sums
      out_word_q.status    <= (in_range || (in_word_i.action == btm_pkg::ACT_NONE)) ?
                              btm_pkg::ST_OK : btm_pkg::ST_RANGE;
      out_word_q.result_re <= '0;
      out_word_q.result_im <= '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  `ASSERT_CLK(a_done_while_busy, clk_i, rst_ni, mac_res.done |-> busy_q, "MAC done while idle")
  `ASSERT_CLK(a_done_out_free, clk_i, rst_ni, mac_res.done |-> !out_valid_q, "output still held at MAC done")
  `ASSERT_NEVER(a_no_accept_busy, clk_i, rst_ni, busy_q && in_accept, "word accepted during compute")
  `ASSERT_CLK(a_start_no_elem, clk_i, rst_ni, start |-> !elem.valid, "compute started mid-scan")

endmodule
